// ----- sv/assert_macros.svh -----
// Assertion macros shared by the detection box decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset; expects clk and rst_n in scope.
`define DBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define DBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/dbd_pkg.sv -----
// Shared types and constants of the detection box decoder.
package dbd_pkg;

  localparam int MAX_CLASSES_DEF = 128;
  localparam int MAX_ANCHORS_DEF = 65536;

  localparam int VALUE_W  = 16;
  localparam int COORD_W  = 18;
  localparam int CLASS_W  = 8;
  localparam int ANCHOR_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Row layout: four box values, then objectness when enabled.
  localparam int BOX_VALUES = 4;
  localparam int HEAD_OBJ   = 5;

  localparam logic        MODE_RST      = 1'b0;
  localparam logic [15:0] THRESHOLD_RST = 16'd16384;
  localparam logic [7:0]  CLASS_CNT_RST = 8'd80;
  localparam logic signed [CLASS_W-1:0] NO_CLASS = -8'sd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OBJ_MODE    = 2'd0,
    CFG_THRESHOLD   = 2'd1,
    CFG_CLASS_COUNT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        objectness_mode;
    logic [15:0] score_threshold;
    logic [7:0]  class_count;
  } dbd_cfg_t;

  // Finished anchor row handed from the row accumulator to the emit stage.
  typedef struct packed {
    logic [VALUE_W-1:0]        cx;
    logic [VALUE_W-1:0]        cy;
    logic [VALUE_W-1:0]        w;
    logic [VALUE_W-1:0]        h;
    logic [VALUE_W-1:0]        obj;
    logic [VALUE_W-1:0]        best_score;
    logic signed [CLASS_W-1:0] best_class;
    logic [ANCHOR_W-1:0]       anchor;
  } dbd_rec_t;

endpackage

// ----- sv/dbd_ifs.sv -----
// Valid/ready channel interfaces for the input values and the decoded boxes.
interface dbd_in_if import dbd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface dbd_out_if import dbd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] left;
  logic signed [COORD_W-1:0] top;
  logic signed [COORD_W-1:0] right;
  logic signed [COORD_W-1:0] bottom;
  logic [VALUE_W-1:0]        confidence;
  logic signed [CLASS_W-1:0] class_idx;
  logic [ANCHOR_W-1:0]       anchor_number;

  modport source (output valid, output left, output top, output right, output bottom,
                  output confidence, output class_idx, output anchor_number, input ready);
  modport sink (input valid, input left, input top, input right, input bottom,
                input confidence, input class_idx, input anchor_number, output ready);
endinterface

// ----- sv/detection_box_decode.sv -----
// Top level of the detection box decoder: config registers, row accumulator, emit stage.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------------
//  in_ch    | in  | valid/ready        | value[15:0]
//  out_ch   | out | valid/ready        | left, top, right, bottom, confidence, class_idx,
//           |     |                    | anchor_number
//  cfg      | in  | cfg_we, no ready   | cfg_index[1:0], cfg_data[15:0]
//
// One value is taken per cycle while input is not held; a result passes through the row
// close register, then the emit register with its multiplier, after the last value of its row.
// Reset is synchronous and clears the config registers, row position, best score and class,
// anchor count and valid flags; stored box fields and objectness are not cleared.
// A stalled result holds the emit register; the row close register still absorbs one
// finished row, and input is held only when both are occupied.
`include "assert_macros.svh"
module detection_box_decode import dbd_pkg::*; #(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int MAX_ANCHORS = MAX_ANCHORS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dbd_in_if.sink                in_ch,
  dbd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dbd_cfg_t cfg_r, cfg_nxt;
  logic     take;
  logic     rec_valid;
  dbd_rec_t rec;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OBJ_MODE:    cfg_nxt.objectness_mode = cfg_data[0];
        CFG_THRESHOLD:   cfg_nxt.score_threshold = cfg_data;
        CFG_CLASS_COUNT: cfg_nxt.class_count     = cfg_data[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.objectness_mode <= MODE_RST;
      cfg_r.score_threshold <= THRESHOLD_RST;
      cfg_r.class_count     <= CLASS_CNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dbd_row #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_ANCHORS (MAX_ANCHORS)
  ) u_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .take      (take),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  dbd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rec_valid (rec_valid),
    .rec       (rec),
    .take      (take),
    .out_ch    (out_ch)
  );

  `DBD_ASSERT_ALWAYS(a_cfg_reset, !rst_n |=> (cfg_r.score_threshold == THRESHOLD_RST)
                     && (cfg_r.class_count == CLASS_CNT_RST), "config not at reset values")

endmodule

// ----- sv/dbd_row.sv -----
// Row accumulator: stores box fields, keeps the running best class and closes rows.
`include "assert_macros.svh"
module dbd_row import dbd_pkg::*; #(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int MAX_ANCHORS = MAX_ANCHORS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dbd_in_if.sink      in_ch,
  input  dbd_cfg_t    cfg,
  input  logic        take,
  output logic        rec_valid,
  output dbd_rec_t    rec
);

  localparam int EFF_MAX = (MAX_CLASSES < 255) ? MAX_CLASSES : 255;
  localparam int POS_W   = $clog2(EFF_MAX + HEAD_OBJ);
  localparam int ANC_W   = $clog2(MAX_ANCHORS);
  localparam logic [7:0]       EFF_MAX8 = 8'(EFF_MAX);
  localparam logic [ANC_W-1:0] ANC_LAST = ANC_W'(MAX_ANCHORS - 1);

  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic [VALUE_W-1:0]        box_r [BOX_VALUES];
  logic [VALUE_W-1:0]        obj_r;
  logic [VALUE_W-1:0]        best_r, best_nxt, cand_best;
  logic signed [CLASS_W-1:0] cls_r, cls_nxt, cand_cls;
  logic [ANC_W-1:0]          anc_r, anc_nxt;
  logic                      rec_v_r, rec_v_nxt;
  dbd_rec_t                  rec_r;

  logic             accept;
  logic             end_row;
  logic [7:0]       eff;
  logic [POS_W-1:0] head;
  logic [POS_W-1:0] last;
  logic [POS_W-1:0] cls_idx;

  assign in_ch.ready = !rec_v_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    if (cfg.class_count == 8'd0) begin
      eff = 8'd1;
    end else if (cfg.class_count > EFF_MAX8) begin
      eff = EFF_MAX8;
    end else begin
      eff = cfg.class_count;
    end
    head    = cfg.objectness_mode ? POS_W'(HEAD_OBJ) : POS_W'(BOX_VALUES);
    last    = head + POS_W'(eff) - POS_W'(1);
    cls_idx = pos_r - head;
  end

  always_comb begin
    pos_nxt   = pos_r;
    best_nxt  = best_r;
    cls_nxt   = cls_r;
    anc_nxt   = anc_r;
    cand_best = best_r;
    cand_cls  = cls_r;
    end_row   = 1'b0;
    if (accept && (pos_r >= head) && !(pos_r < POS_W'(BOX_VALUES))
        && (in_ch.value > best_r)) begin
      cand_best = in_ch.value;
      cand_cls  = CLASS_W'(cls_idx);
    end
    if (accept) begin
      if (pos_r < last) begin
        pos_nxt  = pos_r + POS_W'(1);
        best_nxt = cand_best;
        cls_nxt  = cand_cls;
      end else begin
        end_row  = 1'b1;
        pos_nxt  = '0;
        best_nxt = '0;
        cls_nxt  = NO_CLASS;
        anc_nxt  = (anc_r == ANC_LAST) ? '0 : anc_r + ANC_W'(1);
      end
    end
    if (end_row) begin
      rec_v_nxt = 1'b1;
    end else if (take) begin
      rec_v_nxt = 1'b0;
    end else begin
      rec_v_nxt = rec_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      best_r  <= '0;
      cls_r   <= NO_CLASS;
      anc_r   <= '0;
      rec_v_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      best_r  <= best_nxt;
      cls_r   <= cls_nxt;
      anc_r   <= anc_nxt;
      rec_v_r <= rec_v_nxt;
    end
  end

  // Payload storage; the objectness slot only exists in objectness mode.
  always_ff @(posedge clk) begin
    if (accept && (pos_r < POS_W'(BOX_VALUES))) begin
      box_r[pos_r[1:0]] <= in_ch.value;
    end
    if (accept && (pos_r == POS_W'(BOX_VALUES)) && cfg.objectness_mode) begin
      obj_r <= in_ch.value;
    end
    if (end_row) begin
      rec_r.cx         <= box_r[0];
      rec_r.cy         <= box_r[1];
      rec_r.w          <= box_r[2];
      rec_r.h          <= box_r[3];
      rec_r.obj        <= obj_r;
      rec_r.best_score <= cand_best;
      rec_r.best_class <= cand_cls;
      rec_r.anchor     <= ANCHOR_W'(anc_r);
    end
  end

  assign rec_valid = rec_v_r;
  assign rec       = rec_r;

  `DBD_ASSERT(a_row_end_rec, end_row |=> rec_v_r, "closed row did not produce a record")
  `DBD_ASSERT(a_row_end_clear, end_row |=> (pos_r == '0) && (cls_r == NO_CLASS) && (best_r == '0),
              "row state not cleared after row end")
  `DBD_ASSERT(a_rec_hold, rec_v_r && !take |=> rec_v_r && (rec_r === $past(rec_r)),
              "pending record lost or changed while stalled")

endmodule

// ----- sv/dbd_emit.sv -----
// Emit stage: corner box, confidence product, threshold test and result register.
`include "assert_macros.svh"
module dbd_emit import dbd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dbd_cfg_t  cfg,
  input  logic      rec_valid,
  input  dbd_rec_t  rec,
  output logic      take,
  dbd_out_if.source out_ch
);

  logic                      out_v_r, out_v_nxt;
  logic signed [COORD_W-1:0] left_r, top_r, right_r, bottom_r;
  logic [VALUE_W-1:0]        conf_r;
  logic signed [CLASS_W-1:0] cls_r;
  logic [ANCHOR_W-1:0]       anc_r;

  logic [2*VALUE_W-1:0]      prod;
  logic [VALUE_W-1:0]        conf;
  logic                      keep;
  logic [COORD_W-1:0]        cx, cy, hw, hh;

  assign take = !out_v_r || out_ch.ready;

  always_comb begin
    prod = rec.obj * rec.best_score;
    if (cfg.objectness_mode) begin
      if (rec.obj < cfg.score_threshold) begin
        conf = '0;
        keep = 1'b0;
      end else begin
        conf = prod[2*VALUE_W-1:VALUE_W];
        keep = conf >= cfg.score_threshold;
      end
    end else begin
      conf = rec.best_score;
      keep = conf >= cfg.score_threshold;
    end
    // Half extents drop the lowest bit of width and height.
    cx = COORD_W'(rec.cx);
    cy = COORD_W'(rec.cy);
    hw = COORD_W'(rec.w[VALUE_W-1:1]);
    hh = COORD_W'(rec.h[VALUE_W-1:1]);
    out_v_nxt = take ? (rec_valid && keep) : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && rec_valid) begin
      left_r   <= signed'(cx - hw);
      top_r    <= signed'(cy - hh);
      right_r  <= signed'(cx + hw);
      bottom_r <= signed'(cy + hh);
      conf_r   <= conf;
      cls_r    <= rec.best_class;
      anc_r    <= rec.anchor;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.left          = left_r;
  assign out_ch.top           = top_r;
  assign out_ch.right         = right_r;
  assign out_ch.bottom        = bottom_r;
  assign out_ch.confidence    = conf_r;
  assign out_ch.class_idx     = cls_r;
  assign out_ch.anchor_number = anc_r;

  `DBD_ASSERT(a_drop_rejected, rec_valid && take && !keep |=> !out_v_r,
              "row below threshold produced a result")
  `DBD_ASSERT(a_conf_above_thr, out_v_r |-> conf_r >= cfg.score_threshold,
              "emitted confidence below threshold")
  `DBD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_v_r, "result valid after reset")

endmodule

// ----- dv/detection_box_decode_tb.sv -----
// Self-checking testbench of the detection box decoder, predicting every box from the value stream.
module detection_box_decode_tb;
  import dbd_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int STALL_LIMIT   = 3000;
  localparam int ITEM_TARGET   = 650;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  // Ways of filling the class scores of a row.
  localparam int SCORES_PEAKED = 0;
  localparam int SCORES_RANDOM = 1;
  localparam int SCORES_TIED   = 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    logic [VALUE_W-1:0]        confidence;
    logic signed [CLASS_W-1:0] class_idx;
    logic [ANCHOR_W-1:0]       anchor_number;
  } box_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dbd_in_if  in_ch ();
  dbd_out_if out_ch ();

  detection_box_decode dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies and row state of the predicted decoder.
  logic                      mode_reg      = MODE_RST;
  logic [VALUE_W-1:0]        threshold_reg = THRESHOLD_RST;
  logic [7:0]                class_reg     = CLASS_CNT_RST;
  int                        row_pos       = 0;
  logic [VALUE_W-1:0]        box_val [BOX_VALUES];
  logic [VALUE_W-1:0]        obj_val;
  logic [VALUE_W-1:0]        top_score     = '0;
  logic signed [CLASS_W-1:0] top_class     = NO_CLASS;
  logic [ANCHOR_W-1:0]       anchor_idx    = '0;

  logic [VALUE_W-1:0] value_queue [$];
  box_t               box_queue [$];
  int                 queued_items = 0;
  int                 mismatches   = 0;
  int                 idle_cycles  = 0;
  int                 in_gap       = 0;
  int                 out_gap      = 0;
  int                 hold_left    = 0;
  bit                 value_taken  = 1'b0;
  bit                 no_idle      = 1'b0;
  bit                 hold_request = 1'b0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  function automatic int class_slots();
    if (class_reg == 0) return 1;
    if (class_reg > MAX_CLASSES_DEF) return MAX_CLASSES_DEF;
    return class_reg;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_field();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Consumes one value; returns 1 when the row closes with a box that passes the threshold.
  function automatic bit decode_value(input logic [VALUE_W-1:0] v, output box_t res);
    int                 head;
    int                 last_pos;
    logic [31:0]        product;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] hw;
    logic [COORD_W-1:0] hh;
    bit                 keep;
    head = BOX_VALUES + mode_reg;
    last_pos = head + class_slots() - 1;
    if (row_pos < BOX_VALUES) begin
      box_val[row_pos] = v;
    end else if (row_pos == BOX_VALUES && mode_reg) begin
      obj_val = v;
    end else if (row_pos >= head && v > top_score) begin
      top_score = v;
      top_class = CLASS_W'(row_pos - head);
    end
    res = '0;
    if (row_pos < last_pos) begin
      row_pos++;
      return 1'b0;
    end
    if (!mode_reg) begin
      res.confidence = top_score;
      keep = top_score >= threshold_reg;
    end else if (obj_val < threshold_reg) begin
      res.confidence = '0;
      keep = 1'b0;
    end else begin
      product = obj_val * top_score;
      res.confidence = product[31:16];
      keep = product[31:16] >= threshold_reg;
    end
    cx = {2'b00, box_val[0]};
    cy = {2'b00, box_val[1]};
    hw = {3'b000, box_val[2][VALUE_W-1:1]};
    hh = {3'b000, box_val[3][VALUE_W-1:1]};
    res.left = cx - hw;
    res.top = cy - hh;
    res.right = cx + hw;
    res.bottom = cy + hh;
    res.class_idx = top_class;
    res.anchor_number = anchor_idx;
    anchor_idx++;
    row_pos = 0;
    top_score = '0;
    top_class = NO_CLASS;
    return keep;
  endfunction

  function automatic string box_text(input box_t b);
    return $sformatf("l=%0d t=%0d r=%0d b=%0d conf=%0d class=%0d anchor=%0d",
                     b.left, b.top, b.right, b.bottom, b.confidence, b.class_idx,
                     b.anchor_number);
  endfunction

  task automatic push_value(input logic [VALUE_W-1:0] v);
    value_queue.insert(value_queue.size(), v);
    queued_items++;
  endtask

  task automatic queue_row(input logic [VALUE_W-1:0] cx, cy, w, h, ob,
                           input int style, input logic [VALUE_W-1:0] level);
    int                 slots;
    int                 peak;
    logic [VALUE_W-1:0] s;
    logic [VALUE_W-1:0] peak_val;
    slots = class_slots();
    peak = $urandom_range(0, slots - 1);
    // A peak right at the threshold checks that an equal confidence is kept.
    peak_val = ($urandom_range(0, 3) == 0) ? threshold_reg
                                            : VALUE_W'($urandom_range(16'hC000, 16'hFFFF));
    push_value(cx);
    push_value(cy);
    push_value(w);
    push_value(h);
    if (mode_reg) push_value(ob);
    for (int i = 0; i < slots; i++) begin
      case (style)
        SCORES_RANDOM: s = VALUE_W'($urandom);
        SCORES_TIED:   s = level;
        default:       s = (i == peak) ? peak_val : VALUE_W'($urandom_range(0, 16'h3FFF));
      endcase
      push_value(s);
    end
  endtask

  task automatic queue_random_row();
    logic [VALUE_W-1:0] ob;
    int                 style;
    case ($urandom_range(0, 3))
      0: ob = threshold_reg;
      1: ob = threshold_reg - 1'b1;
      2: ob = '1;
      default: ob = VALUE_W'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2, 3: style = SCORES_PEAKED;
      4, 5:       style = SCORES_RANDOM;
      default:    style = SCORES_TIED;
    endcase
    queue_row(rand_field(), rand_field(), rand_field(), rand_field(), ob, style,
              ($urandom_range(0, 1) == 0) ? '0 : rand_field());
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_OBJ_MODE:    mode_reg = data[0];
      CFG_THRESHOLD:   threshold_reg = data;
      CFG_CLASS_COUNT: class_reg = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Every value taken and every box seen; rows that give no box may still be in flight.
  task automatic wait_idle();
    while (value_queue.size() != 0 || in_ch.valid !== 1'b0 || box_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic mode, input logic [VALUE_W-1:0] thr,
                            input logic [7:0] classes, input bit quiet);
    wait_idle();
    write_reg(CFG_OBJ_MODE, CFG_DATA_W'(mode));
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_CLASS_COUNT, CFG_DATA_W'(classes));
    no_idle = quiet;
  endtask

  task automatic run_phase(input logic mode, input logic [VALUE_W-1:0] thr,
                           input logic [7:0] classes, input int rows, input bit quiet);
    set_config(mode, thr, classes, quiet);
    repeat (rows) queue_random_row();
  endtask

  // Sender: offers queued values, holding each one until its transaction completes.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || value_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (value_queue.size() != 0) begin
        in_ch.value <= value_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      out_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    box_t decoded;
    box_t expected_box;
    box_t got;
    bit   box_taken;
    bit   emit;
    value_taken = rst_n && in_ch.valid && in_ch.ready;
    box_taken = rst_n && out_ch.valid && out_ch.ready;
    if (value_taken) begin
      emit = decode_value(in_ch.value, decoded);
      if (emit) box_queue.insert(box_queue.size(), decoded);
    end
    if (box_taken) begin
      got = '{left: out_ch.left, top: out_ch.top, right: out_ch.right,
              bottom: out_ch.bottom, confidence: out_ch.confidence,
              class_idx: out_ch.class_idx, anchor_number: out_ch.anchor_number};
      if (box_queue.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected box, expected none, actual %s", $time, box_text(got));
      end else begin
        expected_box = box_queue.pop_front();
        if (got !== expected_box) begin
          mismatches++;
          $display("%0t: box mismatch, expected %s, actual %s", $time,
                   box_text(expected_box), box_text(got));
        end
      end
    end
    idle_cycles = (value_taken || box_taken) ? 0 : idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_OBJ_MODE;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // All-zero scores leave the class at minus one; a full tie keeps the first class.
    set_config(1'b0, 16'h0000, 8'd2, 1'b0);
    queue_row('0, '0, '1, '1, '0, SCORES_TIED, '0);
    queue_row('1, '1, '1, '1, '0, SCORES_TIED, '1);

    // Objectness below threshold, full product, and a product that just misses.
    set_config(1'b1, 16'h8000, 8'd1, 1'b0);
    queue_row(16'h8000, 16'h0001, 16'h0001, 16'h0003, 16'h7FFF, SCORES_TIED, '1);
    queue_row(16'h1234, 16'hABCD, 16'h0FFF, 16'h0002, '1, SCORES_TIED, '1);
    queue_row(16'h0010, 16'h0020, 16'h0030, 16'h0040, 16'h8000, SCORES_TIED, '1);

    run_phase(1'b0, 16'h0000, 8'd1, 6, 1'b0);
    run_phase(1'b1, 16'h0000, 8'd1, 6, 1'b1);
    run_phase(1'b0, 16'hFFFF, 8'd4, 6, 1'b0);
    run_phase(1'b1, 16'hFFFF, 8'd3, 6, 1'b0);
    run_phase(1'b0, 16'h4000, 8'd128, 1, 1'b0);
    // A class count above the maximum saturates, zero counts as one class.
    run_phase(1'b1, 16'h2000, 8'd255, 1, 1'b0);
    run_phase(1'b0, 16'h4000, 8'd0, 6, 1'b0);

    // Keep offering values while the receiver stalls, so the block backs up.
    run_phase(1'b0, 16'h1000, 8'd2, 16, 1'b1);
    hold_request = 1'b1;

    while (queued_items < ITEM_TARGET)
      run_phase(1'($urandom_range(0, 1)), VALUE_W'($urandom_range(0, 16'hC000)),
                8'($urandom_range(1, 8)), $urandom_range(4, 12),
                $urandom_range(0, 3) == 0);

    wait_idle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/dbd_pkg.sv
sv/dbd_ifs.sv
sv/dbd_row.sv
sv/dbd_emit.sv
sv/detection_box_decode.sv
dv/detection_box_decode_tb.sv
